// ===== design/sosa_pkg.sv =====
// ----------------------------------------------------------------------------
// sosa_pkg
// Shared types, widths and the reciprocal table for the scaled orientation
// source address core.
// ----------------------------------------------------------------------------
package sosa_pkg;

  localparam int COORD_W     = 14;  // destination coordinate
  localparam int DIM_W       = 11;  // source extent register
  localparam int SCL_W       = 5;   // scale numerator / denominator
  localparam int ORI_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int PROD_W      = COORD_W + SCL_W;   // dest * den
  localparam int RECIP_SHIFT = PROD_W + SCL_W;    // exact for PROD_W-bit dividends
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int MUL_W       = PROD_W + RECIP_W;
  localparam int SGN_W       = PROD_W + 2;        // signed mapped coordinate
  localparam int OUT_W       = 10;
  localparam int IDX_W       = 20;

  typedef enum logic [ORI_W-1:0] {
    ORI_NONE   = 3'd0,
    ORI_FLIP_H = 3'd1,
    ORI_FLIP_V = 3'd2,
    ORI_ROT180 = 3'd3,
    ORI_ROT90  = 3'd4,
    ORI_ROT270 = 3'd5
  } orient_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_SCALE_NUM  = 3'd2,
    CFG_SCALE_DEN  = 3'd3,
    CFG_ORIENT     = 3'd4
  } cfg_reg_t;

  // effective (clamped) configuration seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [SCL_W-1:0] num;
    logic [SCL_W-1:0] den;
    logic [ORI_W-1:0] orient;
  } sosa_cfg_t;

  // ceil(2^RECIP_SHIFT / d); zero divisor never reaches here after clamping
  function automatic logic [RECIP_W-1:0] recip(input logic [SCL_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      5'd2:    r = 25'd8388608;
      5'd3:    r = 25'd5592406;
      5'd4:    r = 25'd4194304;
      5'd5:    r = 25'd3355444;
      5'd6:    r = 25'd2796203;
      5'd7:    r = 25'd2396746;
      5'd8:    r = 25'd2097152;
      5'd9:    r = 25'd1864136;
      5'd10:   r = 25'd1677722;
      5'd11:   r = 25'd1525202;
      5'd12:   r = 25'd1398102;
      5'd13:   r = 25'd1290556;
      5'd14:   r = 25'd1198373;
      5'd15:   r = 25'd1118482;
      5'd16:   r = 25'd1048576;
      5'd17:   r = 25'd986896;
      5'd18:   r = 25'd932068;
      5'd19:   r = 25'd883012;
      5'd20:   r = 25'd838861;
      5'd21:   r = 25'd798916;
      5'd22:   r = 25'd762601;
      5'd23:   r = 25'd729445;
      5'd24:   r = 25'd699051;
      5'd25:   r = 25'd671089;
      5'd26:   r = 25'd645278;
      5'd27:   r = 25'd621379;
      5'd28:   r = 25'd599187;
      5'd29:   r = 25'd578525;
      5'd30:   r = 25'd559241;
      5'd31:   r = 25'd541201;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

endpackage

// ===== design/sosa_scale.sv =====
// ----------------------------------------------------------------------------
// sosa_scale
// Two-stage inverse scaling: dest*den, then division by num through a
// reciprocal multiply.
// ----------------------------------------------------------------------------
module sosa_scale
  import sosa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  sosa_cfg_t          cfg,
  input  logic               up_vld,
  output logic               up_rdy,
  input  logic [COORD_W-1:0] up_x,
  input  logic [COORD_W-1:0] up_y,
  output logic               dn_vld,
  input  logic               dn_rdy,
  output logic [PROD_W-1:0]  dn_sx,
  output logic [PROD_W-1:0]  dn_sy
);

  logic               vld1_r, vld2_r;
  logic               rdy1, rdy2;
  logic [PROD_W-1:0]  px_r, py_r;
  logic [RECIP_W-1:0] recip_r;
  logic [PROD_W-1:0]  px_nxt, py_nxt;
  logic [MUL_W-1:0]   qx_full, qy_full;
  logic [PROD_W-1:0]  sx_r, sy_r;

  assign rdy2   = !vld2_r || dn_rdy;
  assign rdy1   = !vld1_r || rdy2;
  assign up_rdy = rdy1;

  assign px_nxt = PROD_W'(up_x) * PROD_W'(cfg.den);
  assign py_nxt = PROD_W'(up_y) * PROD_W'(cfg.den);

  assign qx_full = MUL_W'(px_r) * MUL_W'(recip_r);
  assign qy_full = MUL_W'(py_r) * MUL_W'(recip_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      if (rdy1) vld1_r <= up_vld;
      if (rdy2) vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_vld) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      recip_r <= recip(cfg.num);
    end
    if (rdy2 && vld1_r) begin
      sx_r <= qx_full[RECIP_SHIFT +: PROD_W];
      sy_r <= qy_full[RECIP_SHIFT +: PROD_W];
    end
  end

  assign dn_vld = vld2_r;
  assign dn_sx  = sx_r;
  assign dn_sy  = sy_r;

endmodule

// ===== design/sosa_orient.sv =====
// ----------------------------------------------------------------------------
// sosa_orient
// Applies the inverse orientation to the scaled coordinate and checks it
// against the source extents.
// ----------------------------------------------------------------------------
module sosa_orient
  import sosa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  sosa_cfg_t         cfg,
  input  logic              up_vld,
  output logic              up_rdy,
  input  logic [PROD_W-1:0] up_sx,
  input  logic [PROD_W-1:0] up_sy,
  output logic              dn_vld,
  input  logic              dn_rdy,
  output logic [DIM_W-1:0]  dn_ux,
  output logic [DIM_W-1:0]  dn_uy,
  output logic              dn_hit
);

  logic                    vld_r;
  logic                    rdy;
  logic signed [SGN_W-1:0] sx_s, sy_s, wm1, hm1, w_s, h_s;
  logic signed [SGN_W-1:0] mx, my;
  logic                    hit;
  logic [DIM_W-1:0]        ux_r, uy_r;
  logic                    hit_r;

  assign rdy    = !vld_r || dn_rdy;
  assign up_rdy = rdy;

  assign sx_s = signed'(SGN_W'(up_sx));
  assign sy_s = signed'(SGN_W'(up_sy));
  assign w_s  = signed'(SGN_W'(cfg.w));
  assign h_s  = signed'(SGN_W'(cfg.h));
  assign wm1  = w_s - SGN_W'(1);
  assign hm1  = h_s - SGN_W'(1);

  always_comb begin
    case (cfg.orient)
      ORI_FLIP_H: begin mx = wm1 - sx_s; my = sy_s;        end
      ORI_FLIP_V: begin mx = sx_s;        my = hm1 - sy_s; end
      ORI_ROT180: begin mx = wm1 - sx_s; my = hm1 - sy_s; end
      ORI_ROT90:  begin mx = sy_s;        my = hm1 - sx_s; end
      ORI_ROT270: begin mx = wm1 - sy_s; my = sx_s;        end
      default:    begin mx = sx_s;        my = sy_s;        end
    endcase
  end

  assign hit = (mx >= 0) && (my >= 0) && (mx < w_s) && (my < h_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && up_vld) begin
      ux_r  <= mx[DIM_W-1:0];
      uy_r  <= my[DIM_W-1:0];
      hit_r <= hit;
    end
  end

  assign dn_vld = vld_r;
  assign dn_ux  = ux_r;
  assign dn_uy  = uy_r;
  assign dn_hit = hit_r;

endmodule

// ===== design/sosa_index.sv =====
// ----------------------------------------------------------------------------
// sosa_index
// Linear source index and output register; misses are zeroed.
// ----------------------------------------------------------------------------
module sosa_index
  import sosa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  sosa_cfg_t        cfg,
  input  logic             up_vld,
  output logic             up_rdy,
  input  logic [DIM_W-1:0] up_ux,
  input  logic [DIM_W-1:0] up_uy,
  input  logic             up_hit,
  output logic             dn_vld,
  input  logic             dn_rdy,
  output logic [OUT_W-1:0] dn_x,
  output logic [OUT_W-1:0] dn_y,
  output logic [IDX_W-1:0] dn_idx,
  output logic             dn_hit
);

  localparam int ROW_W = 2 * DIM_W;

  logic             vld_r;
  logic             rdy;
  logic [ROW_W-1:0] row_off;
  logic [ROW_W-1:0] idx_full;
  logic [OUT_W-1:0] x_r, y_r;
  logic [IDX_W-1:0] idx_r;
  logic             hit_r;

  assign rdy    = !vld_r || dn_rdy;
  assign up_rdy = rdy;

  assign row_off  = ROW_W'(up_uy) * ROW_W'(cfg.w);
  assign idx_full = row_off + ROW_W'(up_ux);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && up_vld) begin
      hit_r <= up_hit;
      x_r   <= up_hit ? up_ux[OUT_W-1:0] : '0;
      y_r   <= up_hit ? up_uy[OUT_W-1:0] : '0;
      idx_r <= up_hit ? idx_full[IDX_W-1:0] : '0;
    end
  end

  assign dn_vld = vld_r;
  assign dn_x   = x_r;
  assign dn_y   = y_r;
  assign dn_idx = idx_r;
  assign dn_hit = hit_r;

endmodule

// ===== design/scaled_orientation_source_address_core.sv =====
// ----------------------------------------------------------------------------
// scaled_orientation_source_address_core
// Nearest-neighbour scale and rotate/flip source address generator.
// ----------------------------------------------------------------------------
// Takes one destination pixel per clock and returns one source address word
// per clock while out_stall is low. The four register stages are dest*den,
// the reciprocal multiply that divides by num (a 19 x 25 bit product), the
// orientation mapping with range check, and the linear index multiply feeding
// the output register. A stall on the output backs up through the stages
// without losing or repeating a word; the input is taken whenever the first
// stage is empty or moving. Registers are to be written only while the
// pipeline is empty; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module scaled_orientation_source_address_core
  import sosa_pkg::*;
#(
  parameter int MAX_DIM   = 1024,
  parameter int MAX_SCALE = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_W-1:0]    in_dest_x,
  input  logic [COORD_W-1:0]    in_dest_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      out_src_x,
  output logic [OUT_W-1:0]      out_src_y,
  output logic [IDX_W-1:0]      out_src_index,
  output logic                  out_hit
);

  logic [DIM_W-1:0]  width_r, height_r;
  logic [SCL_W-1:0]  num_r, den_r;
  logic [ORI_W-1:0]  orient_r;
  sosa_cfg_t         cfg;

  logic              scl_rdy, scl_vld;
  logic [PROD_W-1:0] scl_sx, scl_sy;
  logic              ori_rdy, ori_vld, ori_hit;
  logic [DIM_W-1:0]  ori_ux, ori_uy;
  logic              idx_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      num_r    <= SCL_W'(1);
      den_r    <= SCL_W'(1);
      orient_r <= ORI_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_SRC_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        CFG_SCALE_NUM:  num_r    <= cfg_wdata[SCL_W-1:0];
        CFG_SCALE_DEN:  den_r    <= cfg_wdata[SCL_W-1:0];
        CFG_ORIENT:     orient_r <= cfg_wdata[ORI_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to the supported ranges
  function automatic logic [SCL_W-1:0] clamp_scale(input logic [SCL_W-1:0] v);
    logic [SCL_W-1:0] r;
    if (v == '0) r = SCL_W'(1);
    else if (int'(v) > MAX_SCALE) r = SCL_W'(MAX_SCALE);
    else r = v;
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (int'(v) > MAX_DIM) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  always_comb begin
    cfg.w      = clamp_dim(width_r);
    cfg.h      = clamp_dim(height_r);
    cfg.num    = clamp_scale(num_r);
    cfg.den    = clamp_scale(den_r);
    cfg.orient = orient_r;
  end

  assign in_stall = !scl_rdy;

  sosa_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .up_vld (in_valid),
    .up_rdy (scl_rdy),
    .up_x   (in_dest_x),
    .up_y   (in_dest_y),
    .dn_vld (scl_vld),
    .dn_rdy (ori_rdy),
    .dn_sx  (scl_sx),
    .dn_sy  (scl_sy)
  );

  sosa_orient u_orient (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .up_vld (scl_vld),
    .up_rdy (ori_rdy),
    .up_sx  (scl_sx),
    .up_sy  (scl_sy),
    .dn_vld (ori_vld),
    .dn_rdy (idx_rdy),
    .dn_ux  (ori_ux),
    .dn_uy  (ori_uy),
    .dn_hit (ori_hit)
  );

  sosa_index u_index (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .up_vld (ori_vld),
    .up_rdy (idx_rdy),
    .up_ux  (ori_ux),
    .up_uy  (ori_uy),
    .up_hit (ori_hit),
    .dn_vld (out_valid),
    .dn_rdy (!out_stall),
    .dn_x   (out_src_x),
    .dn_y   (out_src_y),
    .dn_idx (out_src_index),
    .dn_hit (out_hit)
  );

endmodule
